[design/cidp_pkg.sv]
// ----------------------------------------------------------------------------
// cidp_pkg
// Types and constants shared by the caller ID message parser.
// ----------------------------------------------------------------------------
package cidp_pkg;

   localparam int unsigned TakenW = 9;

   localparam logic [7:0] MSG_MULTI  = 8'h80;
   localparam logic [7:0] MSG_SINGLE = 8'h04;
   localparam logic [7:0] KIND_MAX   = 8'h08;
   localparam logic [7:0] CHR_UNAVAIL = 8'h4F;  // 'O'
   localparam logic [7:0] CHR_BLOCKED = 8'h50;  // 'P'
   localparam logic [7:0] SDMF_DT_LEN = 8'd8;

   localparam logic [3:0] KIND_DATETIME   = 4'h1;
   localparam logic [3:0] KIND_NUMBER     = 4'h2;
   localparam logic [3:0] KIND_NUM_ABSENT = 4'h4;
   localparam logic [3:0] KIND_NAME_ABSENT = 4'h8;

   localparam logic [2:0] ST_DATA     = 3'd0;
   localparam logic [2:0] ST_UNAVAIL  = 3'd1;
   localparam logic [2:0] ST_BLOCKED  = 3'd2;
   localparam logic [2:0] ST_EMPTY    = 3'd3;
   localparam logic [2:0] ST_MSG_END  = 3'd4;
   localparam logic [2:0] ST_BAD_TYPE = 3'd5;
   localparam logic [2:0] ST_OVERRUN  = 3'd6;
   localparam logic [2:0] ST_OVERFLOW = 3'd7;

   typedef enum logic [1:0] {
      MODE_HUNT   = 2'd0,
      MODE_MULTI  = 2'd1,
      MODE_SINGLE = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      PH_TYPE = 2'd0,
      PH_LEN  = 2'd1,
      PH_DATA = 2'd2
   } phase_type;

   typedef struct packed {
      mode_type            mode;
      logic [TakenW-1:0]   taken;
      logic [7:0]          body;
      phase_type           phase;
      logic [3:0]          kind;
      logic [7:0]          len;
      logic [7:0]          left;
      logic                skip;
   } parse_state_type;

   localparam parse_state_type STATE_IDLE = '{
      mode:  MODE_HUNT,
      taken: '0,
      body:  '0,
      phase: PH_TYPE,
      kind:  '0,
      len:   '0,
      left:  '0,
      skip:  1'b0
   };

   typedef struct packed {
      logic [2:0] status;
      logic       multi_format;
      logic [3:0] param_kind;
      logic [7:0] param_length;
      logic [7:0] byte_index;
      logic [7:0] data_value;
      logic       last_in_param;
   } result_type;

endpackage

[design/cidp_step.sv]
// ----------------------------------------------------------------------------
// cidp_step
// Per-byte parse step: next parser state and the optional result item.
// ----------------------------------------------------------------------------
module cidp_step
   import cidp_pkg::*;
#(
   parameter int unsigned BUFFER_BYTES = 256
) (
   input  parse_state_type state_cur,
   input  logic [7:0]      rx_byte,
   input  logic            restart,
   output parse_state_type state_in,
   output logic            emit,
   output result_type      result
);

   logic [TakenW-1:0] pos;
   logic [7:0]        remain;
   logic [7:0]        left_dec;
   logic              is_multi;
   logic              is_last;
   logic              absent_kind;

   assign pos         = state_cur.taken - TakenW'(2);
   assign remain      = state_cur.body - (pos[7:0] + 8'd1);
   assign left_dec    = state_cur.left - 8'd1;
   assign is_multi    = (state_cur.mode == MODE_MULTI);
   assign is_last     = (left_dec == 8'd0);
   assign absent_kind = (state_cur.kind == KIND_NUM_ABSENT) ||
                        (state_cur.kind == KIND_NAME_ABSENT);

   always_comb begin
      state_in = state_cur;
      emit     = 1'b0;
      result   = '0;
      result.multi_format = is_multi;
      if (restart) begin
         state_in = STATE_IDLE;
      end else begin
         unique case (state_cur.mode)
            MODE_HUNT: begin
               if (rx_byte == MSG_MULTI) begin
                  state_in.mode  = MODE_MULTI;
                  state_in.taken = TakenW'(1);
               end else if (rx_byte == MSG_SINGLE) begin
                  state_in.mode  = MODE_SINGLE;
                  state_in.taken = TakenW'(1);
               end
            end
            MODE_MULTI, MODE_SINGLE: begin
               priority if (int'(state_cur.taken) >= int'(BUFFER_BYTES)) begin
                  emit              = 1'b1;
                  result.status     = ST_OVERFLOW;
                  result.data_value = rx_byte;
                  state_in          = STATE_IDLE;
               end else if (state_cur.taken < TakenW'(2)) begin
                  state_in.body  = rx_byte;
                  state_in.taken = TakenW'(2);
                  state_in.phase = PH_TYPE;
                  if (!is_multi) begin
                     state_in.kind = KIND_DATETIME;
                     state_in.len  = SDMF_DT_LEN;
                     state_in.left = SDMF_DT_LEN;
                     if (rx_byte < SDMF_DT_LEN) begin
                        state_in.skip       = 1'b1;
                        emit                = 1'b1;
                        result.status       = ST_OVERRUN;
                        result.param_kind   = KIND_DATETIME;
                        result.param_length = SDMF_DT_LEN;
                        result.data_value   = rx_byte;
                     end else begin
                        state_in.phase = PH_DATA;
                     end
                  end
               end else begin
                  state_in.taken = state_cur.taken + TakenW'(1);
                  priority if (pos >= {1'b0, state_cur.body}) begin
                     // checksum position
                     state_in = STATE_IDLE;
                     if (!state_cur.skip) begin
                        emit              = 1'b1;
                        result.data_value = rx_byte;
                        if (is_multi && state_cur.phase == PH_LEN) begin
                           result.status     = ST_OVERRUN;
                           result.param_kind = state_cur.kind;
                        end else begin
                           result.status = ST_MSG_END;
                        end
                     end
                  end else if (state_cur.skip) begin
                     state_in.skip = 1'b1;
                  end else if (is_multi && state_cur.phase == PH_TYPE) begin
                     if (rx_byte > KIND_MAX) begin
                        state_in.skip     = 1'b1;
                        emit              = 1'b1;
                        result.status     = ST_BAD_TYPE;
                        result.data_value = rx_byte;
                     end else begin
                        state_in.kind  = rx_byte[3:0];
                        state_in.phase = PH_LEN;
                     end
                  end else if (is_multi && state_cur.phase == PH_LEN) begin
                     if (rx_byte > remain) begin
                        state_in.skip       = 1'b1;
                        emit                = 1'b1;
                        result.status       = ST_OVERRUN;
                        result.param_kind   = state_cur.kind;
                        result.param_length = rx_byte;
                        result.data_value   = rx_byte;
                     end else begin
                        state_in.len  = rx_byte;
                        state_in.left = rx_byte;
                        if (rx_byte == 8'd0) begin
                           state_in.phase       = PH_TYPE;
                           emit                 = 1'b1;
                           result.status        = ST_EMPTY;
                           result.param_kind    = state_cur.kind;
                           result.last_in_param = 1'b1;
                        end else begin
                           state_in.phase = PH_DATA;
                        end
                     end
                  end else if (state_cur.phase == PH_DATA && state_cur.left != 8'd0) begin
                     state_in.left        = left_dec;
                     emit                 = 1'b1;
                     result.param_kind    = state_cur.kind;
                     result.param_length  = state_cur.len;
                     result.byte_index    = state_cur.len - state_cur.left;
                     result.data_value    = rx_byte;
                     result.last_in_param = is_last;
                     result.status        = ST_DATA;
                     if (absent_kind && state_cur.len == 8'd1) begin
                        if (rx_byte == CHR_UNAVAIL) begin
                           result.status = ST_UNAVAIL;
                        end else if (rx_byte == CHR_BLOCKED) begin
                           result.status = ST_BLOCKED;
                        end
                     end
                     if (is_last) begin
                        if (!is_multi && state_cur.kind == KIND_DATETIME) begin
                           // single format: number takes the rest of the body
                           state_in.kind  = KIND_NUMBER;
                           state_in.len   = state_cur.body - SDMF_DT_LEN;
                           state_in.left  = state_cur.body - SDMF_DT_LEN;
                           state_in.phase = (state_cur.body == SDMF_DT_LEN) ?
                                            PH_TYPE : PH_DATA;
                        end else begin
                           state_in.phase = PH_TYPE;
                        end
                     end
                  end else begin
                     // nothing left to tag: no item
                  end
               end
            end
            default: begin
               state_in = STATE_IDLE;
            end
         endcase
      end
   end

endmodule

[design/caller_id_message_parser.sv]
// ----------------------------------------------------------------------------
// caller_id_message_parser
// Caller ID (single/multiple format) message parser, one received byte per
// item, one tagged result item per data byte, status or error.
// ----------------------------------------------------------------------------
// Any result item of an accepted byte is registered and shows on rsp_ in the next cycle.
// Throughput: 1 byte per cycle; the parse step sits between the input port
// and the result register, stalled only while a result is held unread.
// Reset: synchronous, clears the parser to hunting and drops any held result.
// ----------------------------------------------------------------------------
module caller_id_message_parser
   import cidp_pkg::*;
#(
   parameter int unsigned BUFFER_BYTES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [0:0]  req_tuser,   // [0] restart
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] param_length, [15:8] byte_index,
                                    // [23:16] data_value
   output logic [7:0]  rsp_tuser,   // [2:0] status, [3] multi_format,
                                    // [7:4] param_kind
   output logic        rsp_tlast    // last_in_param
);

   parse_state_type state_ff;
   parse_state_type state_in;
   result_type      rsp_ff;
   result_type      rsp_in;
   logic            rsp_tvalid_ff;
   logic            emit;
   logic            accept;

   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   cidp_step #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_step (
      .state_cur (state_ff),
      .rx_byte   (req_tdata),
      .restart   (req_tuser[0]),
      .state_in  (state_in),
      .emit      (emit),
      .result    (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= STATE_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff      <= state_in;
            rsp_tvalid_ff <= emit;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {rsp_ff.data_value, rsp_ff.byte_index, rsp_ff.param_length};
   assign rsp_tuser  = {rsp_ff.param_kind, rsp_ff.multi_format, rsp_ff.status};
   assign rsp_tlast  = rsp_ff.last_in_param;

endmodule

[design/cidp_checker.sv]
// ----------------------------------------------------------------------------
// cidp_checker
// Port-level checks for the caller ID message parser.
// ----------------------------------------------------------------------------
module cidp_checker
   import cidp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [0:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [7:0]  rsp_tuser,
   input logic        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result item dropped while stalled");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no held result");

   a_restart_quiet: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[0] && (!rsp_tvalid || rsp_tready)
      |=> !rsp_tvalid)
      else $error("restart item produced a result");

   a_empty_param: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2:0] == ST_EMPTY
      |-> rsp_tlast && rsp_tdata[23:16] == 8'd0 && rsp_tdata[7:0] == 8'd0)
      else $error("empty parameter item malformed");

   a_error_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[2:0] == ST_OVERFLOW || rsp_tuser[2:0] == ST_BAD_TYPE)
      |-> rsp_tuser[7:4] == 4'd0 && rsp_tdata[15:0] == 16'd0 && !rsp_tlast)
      else $error("error item carries parameter fields");

endmodule

bind caller_id_message_parser cidp_checker u_cidp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

[tb/caller_id_message_parser_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// caller_id_message_parser_tb
// Self-checking bench for the caller ID parser. A short table of bytes covers
// most status codes; then random single- and multiple-format messages follow,
// some corrupted, cut short by restart, or long enough to overflow the buffer.
// Each accepted byte runs through a parse model in the bench. Every tagged
// result item is checked, field by field, in order.
// ----------------------------------------------------------------------------
module caller_id_message_parser_tb;
   import cidp_pkg::*;

   localparam int         BufBytes  = 256;
   localparam logic [3:0] KIND_NAME = 4'h7;
   localparam int         PlanRows  = 23;
   localparam int         ItemGoal  = 1370;

   typedef struct packed {
      logic [7:0] rx;
      logic       rst;
      logic       typed;
      result_type want;
   } step_row_type;

   // result_type: status, multi_format, kind, length, index, value, last
   localparam step_row_type PLAN [PlanRows] = '{
      '{8'h55, 1'b0, 1'b0, '0},
      '{MSG_MULTI, 1'b0, 1'b0, '0},
      '{8'd9, 1'b0, 1'b0, '0},
      '{{4'h0, KIND_NUM_ABSENT}, 1'b0, 1'b0, '0},
      '{8'd1, 1'b0, 1'b0, '0},
      '{CHR_UNAVAIL, 1'b0, 1'b1,
        '{ST_UNAVAIL, 1'b1, KIND_NUM_ABSENT, 8'd1, 8'd0, CHR_UNAVAIL, 1'b1}},
      '{{4'h0, KIND_NAME_ABSENT}, 1'b0, 1'b0, '0},
      '{8'd1, 1'b0, 1'b0, '0},
      '{CHR_BLOCKED, 1'b0, 1'b1,
        '{ST_BLOCKED, 1'b1, KIND_NAME_ABSENT, 8'd1, 8'd0, CHR_BLOCKED, 1'b1}},
      '{{4'h0, KIND_NAME}, 1'b0, 1'b0, '0},
      '{8'd0, 1'b0, 1'b1,
        '{ST_EMPTY, 1'b1, KIND_NAME, 8'd0, 8'd0, 8'd0, 1'b1}},
      '{{4'h0, KIND_NUMBER}, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b1,
        '{ST_OVERRUN, 1'b1, KIND_NUMBER, 8'd0, 8'd0, 8'hFF, 1'b0}},
      '{MSG_MULTI, 1'b0, 1'b0, '0},
      '{8'h10, 1'b0, 1'b0, '0},
      '{8'h00, 1'b1, 1'b0, '0},
      '{MSG_MULTI, 1'b0, 1'b0, '0},
      '{8'd1, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b1,
        '{ST_BAD_TYPE, 1'b1, 4'h0, 8'd0, 8'd0, 8'hFF, 1'b0}},
      '{8'hA5, 1'b0, 1'b0, '0},
      '{MSG_SINGLE, 1'b0, 1'b0, '0},
      '{8'd7, 1'b0, 1'b1,
        '{ST_OVERRUN, 1'b0, KIND_DATETIME, SDMF_DT_LEN, 8'd0, 8'd7, 1'b0}},
      '{8'h3C, 1'b1, 1'b0, '0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;     // [7:0] rx_byte
   logic [0:0]  req_tuser = '0;     // [0] restart
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;          // [7:0] param_length, [15:8] byte_index,
                                    // [23:16] data_value
   logic [7:0]  rsp_tuser;          // [2:0] status, [3] multi_format,
                                    // [7:4] param_kind
   logic        rsp_tlast;

   result_type  owed_tags [$];
   int          errors = 0;
   int          busy_items = 0;
   int          burst_left = 0;
   logic        hold_off = 1'b0;
   int unsigned rx_tick = 0;

   // parse model state
   mode_type    cid_mode = MODE_HUNT;
   logic [8:0]  cid_taken = '0;
   logic [7:0]  cid_body = '0;
   phase_type   cid_phase = PH_TYPE;
   logic [3:0]  cid_kind = '0;
   logic [7:0]  cid_len = '0;
   logic [7:0]  cid_left = '0;
   logic        cid_skip = 1'b0;

   caller_id_message_parser #(.BUFFER_BYTES(BufBytes)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void drop_message();
      cid_mode  = MODE_HUNT;
      cid_taken = '0;
      cid_body  = '0;
      cid_phase = PH_TYPE;
      cid_kind  = '0;
      cid_len   = '0;
      cid_left  = '0;
      cid_skip  = 1'b0;
   endfunction

   function automatic bit parse_byte(input logic [7:0] b, input logic rst,
                                     output result_type r);
      int pos;
      bit got;
      r = '0;
      got = 1'b0;
      if (rst) begin
         drop_message();
         return 1'b0;
      end
      if (cid_mode == MODE_HUNT) begin
         if (b == MSG_MULTI) cid_mode = MODE_MULTI;
         else if (b == MSG_SINGLE) cid_mode = MODE_SINGLE;
         else return 1'b0;
         cid_taken = 9'd1;
         return 1'b0;
      end
      r.multi_format = (cid_mode == MODE_MULTI);
      if (cid_taken >= BufBytes) begin
         r.status = ST_OVERFLOW;
         r.data_value = b;
         drop_message();
         return 1'b1;
      end
      if (cid_taken < 2) begin
         cid_body  = b;
         cid_taken = 9'd2;
         cid_phase = PH_TYPE;
         if (cid_mode == MODE_SINGLE) begin
            cid_kind = KIND_DATETIME;
            cid_len  = SDMF_DT_LEN;
            cid_left = SDMF_DT_LEN;
            if (b < SDMF_DT_LEN) begin
               cid_skip = 1'b1;
               r.status = ST_OVERRUN;
               r.param_kind = KIND_DATETIME;
               r.param_length = SDMF_DT_LEN;
               r.data_value = b;
               return 1'b1;
            end
            cid_phase = PH_DATA;
         end
         return 1'b0;
      end

      pos = int'(cid_taken) - 2;
      cid_taken = cid_taken + 9'd1;

      if (pos >= int'(cid_body)) begin
         if (!cid_skip) begin
            got = 1'b1;
            r.data_value = b;
            if (cid_mode == MODE_MULTI && cid_phase == PH_LEN) begin
               r.status = ST_OVERRUN;
               r.param_kind = cid_kind;
            end else begin
               r.status = ST_MSG_END;
            end
         end
         drop_message();
         return got;
      end
      if (cid_skip) return 1'b0;

      if (cid_mode == MODE_MULTI && cid_phase == PH_TYPE) begin
         if (b > KIND_MAX) begin
            cid_skip = 1'b1;
            r.status = ST_BAD_TYPE;
            r.data_value = b;
            return 1'b1;
         end
         cid_kind  = b[3:0];
         cid_phase = PH_LEN;
         return 1'b0;
      end
      if (cid_mode == MODE_MULTI && cid_phase == PH_LEN) begin
         if (int'(b) > int'(cid_body) - (pos + 1)) begin
            cid_skip = 1'b1;
            r.status = ST_OVERRUN;
            r.param_kind = cid_kind;
            r.param_length = b;
            r.data_value = b;
            return 1'b1;
         end
         cid_len  = b;
         cid_left = b;
         if (b == 8'd0) begin
            cid_phase = PH_TYPE;
            r.status = ST_EMPTY;
            r.param_kind = cid_kind;
            r.last_in_param = 1'b1;
            return 1'b1;
         end
         cid_phase = PH_DATA;
         return 1'b0;
      end
      if (cid_phase != PH_DATA || cid_left == 8'd0) return 1'b0;

      r.byte_index = cid_len - cid_left;
      cid_left = cid_left - 8'd1;
      r.last_in_param = (cid_left == 8'd0);
      r.status = ST_DATA;
      if ((cid_kind == KIND_NUM_ABSENT || cid_kind == KIND_NAME_ABSENT) &&
          cid_len == 8'd1) begin
         if (b == CHR_UNAVAIL) r.status = ST_UNAVAIL;
         else if (b == CHR_BLOCKED) r.status = ST_BLOCKED;
      end
      r.param_kind = cid_kind;
      r.param_length = cid_len;
      r.data_value = b;
      if (r.last_in_param) begin
         if (cid_mode == MODE_SINGLE && cid_kind == KIND_DATETIME) begin
            cid_kind  = KIND_NUMBER;
            cid_len   = cid_body - SDMF_DT_LEN;
            cid_left  = cid_len;
            cid_phase = (cid_left == 8'd0) ? PH_TYPE : PH_DATA;
         end else begin
            cid_phase = PH_TYPE;
         end
      end
      return 1'b1;
   endfunction

   task automatic send_item(input logic [7:0] b, input logic rst, input logic typed,
                            input result_type want);
      result_type pred;
      bit got;
      bit was_busy;
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(3, 0) == 0) gap = 0;
         else if ($urandom_range(9, 0) == 0) gap = $urandom_range(40, 13);
         else gap = $urandom_range(12, 1);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(9, 0) == 0) ? $urandom_range(300, 100)
                                                   : $urandom_range(24, 1);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= rst;
      do @(posedge clock); while (!req_tready);
      was_busy = (cid_mode != MODE_HUNT);
      got = parse_byte(b, rst, pred);
      if (was_busy || cid_mode != MODE_HUNT) busy_items++;
      if (typed) owed_tags.push_back(want);
      else if (got) owed_tags.push_back(pred);
      burst_left--;
   endtask

   task automatic drain_owed();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (owed_tags.size() != 0);
      burst_left = 0;
   endtask

   task automatic run_message(input bit go_long);
      logic [7:0] msg [$];
      logic [3:0] kind;
      int body, left, plen, cap, cut, i, pick;
      bit multi;
      multi = 1'($urandom_range(1, 0));
      cap = go_long ? 255 : 10;
      if (go_long) body = $urandom_range(255, 250);
      else if (multi) body = $urandom_range(40, 0);
      else body = 8 + (($urandom_range(4, 0) == 0) ? 0 : $urandom_range(14, 1));

      if (multi) begin
         msg.push_back(MSG_MULTI);
         msg.push_back(8'(body));
         left = body;
         while (left > 0) begin
            pick = $urandom_range(5, 0);
            case (pick)
               0: kind = KIND_DATETIME;
               1: kind = KIND_NUMBER;
               2: kind = KIND_NUM_ABSENT;
               3: kind = KIND_NAME;
               4: kind = KIND_NAME_ABSENT;
               default: kind = 4'($urandom_range(8, 0));
            endcase
            msg.push_back({4'h0, kind});
            if (left == 1) begin
               left = 0;
            end else begin
               if ((kind == KIND_NUM_ABSENT || kind == KIND_NAME_ABSENT) && left >= 3 &&
                   $urandom_range(3, 0) != 0) plen = 1;
               else plen = $urandom_range((left - 2 < cap) ? left - 2 : cap, 0);
               msg.push_back(8'(plen));
               for (i = 0; i < plen; i++) begin
                  if (plen == 1 && $urandom_range(2, 0) == 0) msg.push_back(CHR_UNAVAIL);
                  else if (plen == 1 && $urandom_range(1, 0) == 0) msg.push_back(CHR_BLOCKED);
                  else msg.push_back(8'($urandom));
               end
               left -= 2 + plen;
            end
         end
      end else begin
         msg.push_back(MSG_SINGLE);
         msg.push_back(8'(body));
         for (i = 0; i < body; i++) begin
            if (i < 8 && $urandom_range(3, 0) != 0) msg.push_back(8'(8'h30 + $urandom_range(9, 0)));
            else msg.push_back(8'($urandom));
         end
      end

      // corrupt about a quarter of the messages
      if ($urandom_range(3, 0) == 0) begin
         i = $urandom_range(msg.size() - 1, 1);
         msg[i] = $urandom_range(1, 0) ? 8'($urandom) : 8'($urandom_range(255, 9));
         if ($urandom_range(2, 0) == 0) msg[1] = 8'($urandom_range(12, 0));
      end
      msg.push_back(8'($urandom));

      if ($urandom_range(7, 0) == 0) begin
         pick = $urandom_range(4, 1);
         for (i = 0; i < pick; i++) send_item(8'($urandom), 1'b0, 1'b0, '0);
      end
      if ($urandom_range(19, 0) == 0) send_item(8'($urandom), 1'b1, 1'b0, '0);

      cut = ($urandom_range(15, 0) == 0) ? $urandom_range(msg.size() - 1, 0) : msg.size();
      for (i = 0; i < cut; i++) send_item(msg[i], 1'b0, 1'b0, '0);
      if (cut < msg.size()) send_item(8'($urandom), 1'b1, 1'b0, '0);
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] seen);
      if (want !== seen) begin
         $error("%s: expected %0h, got %0h", name, want, seen);
         errors++;
      end
   endtask

   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (owed_tags.size() == 0) begin
            $error("result item with none outstanding: tuser %0h tdata %0h",
                   rsp_tuser, rsp_tdata);
            errors++;
         end else begin
            want = owed_tags.pop_front();
            check_field("status", 8'(want.status), 8'(rsp_tuser[2:0]));
            check_field("multi_format", 8'(want.multi_format), 8'(rsp_tuser[3]));
            check_field("param_kind", 8'(want.param_kind), 8'(rsp_tuser[7:4]));
            check_field("param_length", want.param_length, rsp_tdata[7:0]);
            check_field("byte_index", want.byte_index, rsp_tdata[15:8]);
            check_field("data_value", want.data_value, rsp_tdata[23:16]);
            check_field("last_in_param", 8'(want.last_in_param), 8'(rsp_tlast));
         end
      end
   end

   always @(posedge clock) begin
      rx_tick = rx_tick + 1;
      case (rx_tick[8:7])
         2'd0: rsp_tready <= !hold_off;
         2'd1: rsp_tready <= !hold_off && ($urandom_range(1, 0) == 1);
         2'd2: rsp_tready <= !hold_off && (rx_tick[2:0] != 3'd0);
         default: rsp_tready <= !hold_off && ($urandom_range(3, 0) == 0);
      endcase
   end

   // long receiver hold-off while the sender keeps offering
   initial begin
      wait (busy_items >= 600);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (300) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin : stimulus
      int n;
      int msgs;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (n = 0; n < PlanRows; n++)
         send_item(PLAN[n].rx, PLAN[n].rst, PLAN[n].typed, PLAN[n].want);
      drain_owed();
      msgs = 0;
      while (busy_items < ItemGoal) begin
         run_message(msgs == 0 || $urandom_range(49, 0) == 0);
         msgs++;
         if (msgs % 12 == 0 && !hold_off) drain_owed();
      end
      drain_owed();
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("caller_id_message_parser regression: pass");
      end else begin
         $display("caller_id_message_parser regression: fail");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("caller_id_message_parser regression: fail");
      $finish;
   end

endmodule
